### src/ciea_pkg.sv
// ----------------------------------------------------------------------------
// ciea_pkg - shared types and constants of the checked integer ALU
// Word layouts of both channels, operation codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package ciea_pkg;

    localparam int DATA_W    = 64;
    localparam int HALF_W    = 32;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 8;

    // Operation codes; codes above OP_RELU give a zero result, no overflow.
    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_NEG  = 3'd3,
        OP_RELU = 3'd4
    } op_e;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_WIDTH = 4'd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     overflow;
    } out_word_t;

    // Side band that rides along the multiplier pipeline.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              ovf;
        logic              is_mul;
        logic              neg;
        logic              wide;
    } side_t;

endpackage : ciea_pkg

`default_nettype wire

### src/ciea_flow.sv
// ----------------------------------------------------------------------------
// ciea_flow - valid/ready flow control of the stage chain
// Per-stage valid bits; a stage loads when it is empty or its successor loads.
// ----------------------------------------------------------------------------
`default_nettype none

module ciea_flow #(
    parameter int DEPTH = 6
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             out_ready,
    output logic [DEPTH-1:0]      stage_en,
    output logic                  out_valid
);

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic [DEPTH:0]   rdy;

    always_comb begin
        rdy[DEPTH] = out_ready;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (rdy[0]) begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < DEPTH; k++) begin
            if (rdy[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = rdy[0];
    assign stage_en  = rdy[DEPTH-1:0];
    assign out_valid = vld_reg[DEPTH-1];

endmodule : ciea_flow

`default_nettype wire

### src/ciea_mul.sv
// ----------------------------------------------------------------------------
// ciea_mul - pipelined 64x64 unsigned multiplier
// Four 32x32 partial products, cross-term add, then final 128-bit add.
// ----------------------------------------------------------------------------
`default_nettype none

module ciea_mul (
    input  wire logic                              aclk,
    input  wire logic [2:0]                        en,
    input  wire logic [ciea_pkg::DATA_W-1:0]       mag_a,
    input  wire logic [ciea_pkg::DATA_W-1:0]       mag_b,
    output logic      [2*ciea_pkg::DATA_W-1:0]     product
);

    localparam int W = ciea_pkg::DATA_W;
    localparam int H = ciea_pkg::HALF_W;

    logic [W-1:0]   pll_reg, plh_reg, phl_reg, phh_reg;
    logic [W-1:0]   pll_next, plh_next, phl_next, phh_next;
    logic [W-1:0]   lo2_reg, hi2_reg;
    logic [W:0]     mid_reg, mid_next;
    logic [2*W-1:0] prod_reg, prod_next;

    always_comb begin
        pll_next = W'(mag_a[H-1:0]) * W'(mag_b[H-1:0]);
        plh_next = W'(mag_a[H-1:0]) * W'(mag_b[W-1:H]);
        phl_next = W'(mag_a[W-1:H]) * W'(mag_b[H-1:0]);
        phh_next = W'(mag_a[W-1:H]) * W'(mag_b[W-1:H]);
    end

    assign mid_next  = {1'b0, plh_reg} + {1'b0, phl_reg};
    assign prod_next = {hi2_reg, lo2_reg} + {(W - H - 1)'(0), mid_reg, H'(0)};

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pll_reg <= pll_next;
            plh_reg <= plh_next;
            phl_reg <= phl_next;
            phh_reg <= phh_next;
        end
        if (en[1]) begin
            mid_reg <= mid_next;
            lo2_reg <= pll_reg;
            hi2_reg <= phh_reg;
        end
        if (en[2]) begin
            prod_reg <= prod_next;
        end
    end

    assign product = prod_reg;

endmodule : ciea_mul

`default_nettype wire

### src/checked_integer_elementwise_alu.sv
// ----------------------------------------------------------------------------
// checked_integer_elementwise_alu - overflow-checked signed integer ALU
// Elementwise add, subtract, multiply, negate and relu at 32 or 64 bits.
// ----------------------------------------------------------------------------
// The block takes one input word per clock while the result side is not
// stalled and returns one result word per input word, in order. Six
// registers lie between the ports, the input register first and the
// result register last, and each word passes through them in that order
// before its result word is offered. Throughput is one word every cycle
// when not stalled: the only long path, the 64x64 multiply, is split into
// four 32x32 partial products followed by a cross-term add and a final
// 128-bit add, each in a stage of its own, and
// every operation travels through the same six stages. Stalls on the result
// side back up stage by stage, so empty stages still take new words while a
// finished result waits. op_mode and element_width apply to every word;
// write them only while no word is in flight. In 32-bit mode the low 32 bits
// of each operand are used as a signed value and the result is
// sign-extended. When the exact result leaves the element range, the result
// is zero and overflow is set. Unused operation codes give zero, no overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module checked_integer_elementwise_alu (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input words
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire ciea_pkg::in_word_t                  s_data,
    // result words
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output ciea_pkg::out_word_t                      m_data,
    // configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ciea_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ciea_pkg::CFG_DAT_W-1:0]      cfg_data
);

    localparam int W     = ciea_pkg::DATA_W;
    localparam int H     = ciea_pkg::HALF_W;
    localparam int DEPTH = 6;

    // ---------------------------------------------------------------- config
    ciea_pkg::op_e op_mode_reg;
    logic          wide_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg <= ciea_pkg::OP_ADD;
            wide_reg    <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == ciea_pkg::CFG_OP_MODE) begin
                op_mode_reg <= ciea_pkg::op_e'(cfg_data[2:0]);
            end
            if (cfg_index == ciea_pkg::CFG_ELEM_WIDTH) begin
                wide_reg <= cfg_data[0];
            end
        end
    end

    // ----------------------------------------------------------- flow control
    logic [DEPTH-1:0] en;

    ciea_flow #(
        .DEPTH (DEPTH)
    ) u_flow (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_ready (m_ready),
        .stage_en  (en),
        .out_valid (m_valid)
    );

    // ------------------------------------------- stage 0: input word register
    // Narrow mode: sign-extend the low half here so all later math is 64-bit.
    logic [W-1:0]  a0_reg, b0_reg, a0_next, b0_next;
    ciea_pkg::op_e op0_reg;
    logic          wide0_reg;

    always_comb begin
        if (wide_reg) begin
            a0_next = s_data.operand_a;
            b0_next = s_data.operand_b;
        end else begin
            a0_next = {{(W - H){s_data.operand_a[H-1]}}, s_data.operand_a[H-1:0]};
            b0_next = {{(W - H){s_data.operand_b[H-1]}}, s_data.operand_b[H-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a0_reg    <= a0_next;
            b0_reg    <= b0_next;
            op0_reg   <= op_mode_reg;
            wide0_reg <= wide_reg;
        end
    end

    // ------------------------------- stage 1: add/sub/neg/relu and magnitudes
    logic [W-1:0]    sum0, diff0, negv0;
    logic            fit_sum, fit_diff, fit_neg;
    ciea_pkg::side_t side1_reg, side1_next;
    logic [W-1:0]    ua1_reg, ub1_reg, ua1_next, ub1_next;

    assign sum0  = a0_reg + b0_reg;
    assign diff0 = a0_reg - b0_reg;
    assign negv0 = ~a0_reg + W'(1);

    // Value fits 32 bits when its top bits are all copies of bit 31.
    assign fit_sum  = (&sum0[W-1:H-1])  || ~(|sum0[W-1:H-1]);
    assign fit_diff = (&diff0[W-1:H-1]) || ~(|diff0[W-1:H-1]);
    assign fit_neg  = (&negv0[W-1:H-1]) || ~(|negv0[W-1:H-1]);

    always_comb begin
        side1_next.value  = '0;
        side1_next.ovf    = 1'b0;
        side1_next.is_mul = 1'b0;
        side1_next.neg    = a0_reg[W-1] ^ b0_reg[W-1];
        side1_next.wide   = wide0_reg;
        case (op0_reg)
            ciea_pkg::OP_ADD: begin
                side1_next.value = sum0;
                side1_next.ovf   = wide0_reg
                    ? ((a0_reg[W-1] == b0_reg[W-1]) && (sum0[W-1] != a0_reg[W-1]))
                    : !fit_sum;
            end
            ciea_pkg::OP_SUB: begin
                side1_next.value = diff0;
                side1_next.ovf   = wide0_reg
                    ? ((a0_reg[W-1] != b0_reg[W-1]) && (diff0[W-1] != a0_reg[W-1]))
                    : !fit_diff;
            end
            ciea_pkg::OP_MUL: begin
                side1_next.is_mul = 1'b1;
            end
            ciea_pkg::OP_NEG: begin
                side1_next.value = negv0;
                side1_next.ovf   = wide0_reg
                    ? (a0_reg == {1'b1, (W - 1)'(0)})
                    : !fit_neg;
            end
            ciea_pkg::OP_RELU: begin
                side1_next.value = a0_reg[W-1] ? '0 : a0_reg;
            end
            default: begin
                side1_next.value = '0;
            end
        endcase
        // Overflow forces a zero result.
        if (side1_next.ovf) begin
            side1_next.value = '0;
        end
    end

    assign ua1_next = a0_reg[W-1] ? negv0 : a0_reg;
    assign ub1_next = b0_reg[W-1] ? (~b0_reg + W'(1)) : b0_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            side1_reg <= side1_next;
            ua1_reg   <= ua1_next;
            ub1_reg   <= ub1_next;
        end
    end

    // -------------------------------- stages 2..4: multiplier and side band
    logic [2*W-1:0]  prod;
    ciea_pkg::side_t side2_reg, side3_reg, side4_reg;

    ciea_mul u_mul (
        .aclk    (aclk),
        .en      (en[4:2]),
        .mag_a   (ua1_reg),
        .mag_b   (ub1_reg),
        .product (prod)
    );

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            side2_reg <= side1_reg;
        end
        if (en[3]) begin
            side3_reg <= side2_reg;
        end
        if (en[4]) begin
            side4_reg <= side3_reg;
        end
    end

    // --------------------------------- stage 5: range check, result register
    // Product magnitude limit is 2^(n-1) for a negative result, else one less.
    logic               mul_ovf;
    logic [W-1:0]       mul_val;
    ciea_pkg::out_word_t out_reg, out_next;

    always_comb begin
        if (side4_reg.wide) begin
            mul_ovf = (|prod[2*W-1:W])
                   || (prod[W-1] && (side4_reg.neg ? (|prod[W-2:0]) : 1'b1));
        end else begin
            mul_ovf = (|prod[2*W-1:H])
                   || (prod[H-1] && (side4_reg.neg ? (|prod[H-2:0]) : 1'b1));
        end
        mul_val = side4_reg.neg ? (~prod[W-1:0] + W'(1)) : prod[W-1:0];

        if (side4_reg.is_mul) begin
            out_next.result   = mul_ovf ? '0 : mul_val;
            out_next.overflow = mul_ovf;
        end else begin
            out_next.result   = side4_reg.value;
            out_next.overflow = side4_reg.ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule : checked_integer_elementwise_alu

`default_nettype wire
